// ----- hw/rtl/tbc_pkg.sv -----
// Shared types and constants for the take-back-half controller.
// Holds field widths, register indexes, sequencer states and serial unit structs.
// No dependencies.
package tbc_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int TIME_BITS     = 32;
  localparam int GAIN_BITS     = 24;
  localparam int FIX_BITS      = 32;
  localparam int DRIVE_BITS    = 17;
  localparam int FRAC_BITS     = 24;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 32;

  // serial unit geometry
  localparam int MCAND_W       = GAIN_BITS + SAMPLE_BITS;   // gain * |error|
  localparam int MPLR_W        = TIME_BITS + 1;             // elapsed + interval
  localparam int PROD_W        = MCAND_W + MPLR_W;
  localparam int ACC_W         = MCAND_W + 1;
  localparam int DIVR_W        = TIME_BITS;
  localparam int MUL_STEPS     = MPLR_W;
  localparam int DIV_STEPS     = PROD_W;
  localparam int UNIT_CNT_BITS = $clog2(DIV_STEPS);

  // integral arithmetic
  localparam int TOTAL_W       = FRAC_BITS + 10;            // step cap is 2^33
  localparam int INT_EXT_W     = TOTAL_W + 2;
  localparam int SUM_W         = MCAND_W + 2;

  localparam logic [FIX_BITS-1:0]   ONE_Q24         = FIX_BITS'(1) << FRAC_BITS;
  localparam logic [TIME_BITS-1:0]  IV_RESET        = TIME_BITS'(1000);
  localparam logic [TOTAL_W-1:0]    STEP_CAP        = TOTAL_W'(1) << (TOTAL_W - 1);
  localparam logic [DRIVE_BITS-1:0] DRIVE_FULL      = DRIVE_BITS'(1) << (DRIVE_BITS - 1);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_SET_POINT   = 3'd0,
    REG_KP_GAIN     = 3'd1,
    REG_KI_GAIN     = 3'd2,
    REG_INTERVAL    = 3'd3,
    REG_ENABLE      = 3'd4,
    REG_INT_LOW     = 3'd5,
    REG_INT_HIGH    = 3'd6
  } tbc_reg_e;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] set_point;
    logic [GAIN_BITS-1:0]   kp_gain;
    logic [GAIN_BITS-1:0]   ki_gain;
    logic [TIME_BITS-1:0]   update_interval;
    logic                   enable;
    logic [FIX_BITS-1:0]    int_low;
    logic [FIX_BITS-1:0]    int_high;
  } tbc_cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL_STEP,
    ST_MUL_SPAN,
    ST_DIV_SPAN,
    ST_INTEG,
    ST_CROSS,
    ST_LIMIT,
    ST_MUL_KP,
    ST_DRIVE,
    ST_FINISH
  } tbc_state_e;

  typedef enum logic {
    OP_MUL,
    OP_DIV
  } tbc_op_e;

  typedef struct packed {
    logic                start;
    tbc_op_e             op;
    logic [PROD_W-1:0]   a;   // multiplicand (low bits) or dividend
    logic [MPLR_W-1:0]   b;   // multiplier or divisor (low bits)
  } tbc_cmd_t;

  typedef struct packed {
    logic                done;
    logic [PROD_W-1:0]   res;
  } tbc_sts_t;

endpackage

// ----- hw/rtl/tbc_if.sv -----
// Handshake channels of the take-back-half controller: samples, results, register writes.
// Depends on tbc_pkg for field widths.
interface tbc_sample_if;
  logic                            valid;
  logic                            ready;
  logic [tbc_pkg::SAMPLE_BITS-1:0] measurement;
  logic [tbc_pkg::TIME_BITS-1:0]   now;

  modport source (output valid, output measurement, output now, input ready);
  modport sink   (input valid, input measurement, input now, output ready);
endinterface

interface tbc_result_if;
  logic                           valid;
  logic                           ready;
  logic                           updated;
  logic [tbc_pkg::DRIVE_BITS-1:0] drive;

  modport source (output valid, output updated, output drive, input ready);
  modport sink   (input valid, input updated, input drive, output ready);
endinterface

interface tbc_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [tbc_pkg::CFG_IDX_BITS-1:0]  index;
  logic [tbc_pkg::CFG_DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/tbc_cfg_regs.sv -----
// Configuration register file of the take-back-half controller.
// Depends on tbc_pkg and tbc_cfg_if.
module tbc_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  tbc_cfg_if.sink           cfg_i,
  output tbc_pkg::tbc_cfg_t cfg_o
);
  import tbc_pkg::*;

  tbc_cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.set_point       <= '0;
      cfg_q.kp_gain         <= '0;
      cfg_q.ki_gain         <= '0;
      cfg_q.update_interval <= IV_RESET;
      cfg_q.enable          <= 1'b0;
      cfg_q.int_low         <= '0;
      cfg_q.int_high        <= ONE_Q24;
    end else if (cfg_i.valid) begin
      unique case (tbc_reg_e'(cfg_i.index))
        REG_SET_POINT: cfg_q.set_point       <= cfg_i.data[SAMPLE_BITS-1:0];
        REG_KP_GAIN:   cfg_q.kp_gain         <= cfg_i.data[GAIN_BITS-1:0];
        REG_KI_GAIN:   cfg_q.ki_gain         <= cfg_i.data[GAIN_BITS-1:0];
        REG_INTERVAL:  cfg_q.update_interval <= cfg_i.data[TIME_BITS-1:0];
        REG_ENABLE:    cfg_q.enable          <= cfg_i.data[0];
        REG_INT_LOW:   cfg_q.int_low         <= cfg_i.data[FIX_BITS-1:0];
        REG_INT_HIGH:  cfg_q.int_high        <= cfg_i.data[FIX_BITS-1:0];
        default: ;  // unmapped index, drop the write
      endcase
    end
  end

endmodule

// ----- hw/rtl/tbc_serial_unit.sv -----
// Shared bit-serial multiply / restoring divide unit built around one adder.
// One product or quotient bit per cycle; depends on tbc_pkg.
module tbc_serial_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tbc_pkg::tbc_cmd_t cmd_i,
  output tbc_pkg::tbc_sts_t sts_o
);
  import tbc_pkg::*;

  logic                     busy_q, done_q;
  tbc_op_e                  op_q;
  logic [UNIT_CNT_BITS-1:0] cnt_q;
  logic [ACC_W-1:0]         acc_q, acc_d;
  logic [PROD_W-1:0]        sh_q, sh_d;
  logic [MCAND_W-1:0]       opnd_q;

  logic [DIVR_W:0]          rr;
  logic [ACC_W-1:0]         a_add, b_add, b_eff;
  logic                     sub;
  logic [ACC_W:0]           sum;

  // remainder shifted left with the next dividend bit
  assign rr    = {acc_q[DIVR_W-1:0], sh_q[PROD_W-1]};
  assign sub   = (op_q == OP_DIV);
  assign a_add = sub ? {{(ACC_W-DIVR_W-1){1'b0}}, rr} : acc_q;
  assign b_add = (sub || sh_q[0]) ? {1'b0, opnd_q} : '0;
  assign b_eff = sub ? ~b_add : b_add;
  assign sum   = {1'b0, a_add} + {1'b0, b_eff} + {{ACC_W{1'b0}}, sub};

  always_comb begin
    if (sub) begin
      acc_d = sum[ACC_W] ? {{(ACC_W-DIVR_W-1){1'b0}}, sum[DIVR_W:0]}
                         : {{(ACC_W-DIVR_W-1){1'b0}}, rr};
      sh_d  = {sh_q[PROD_W-2:0], sum[ACC_W]};
    end else begin
      acc_d = {1'b0, sum[ACC_W-1:1]};
      sh_d  = {sh_q[PROD_W-1:MPLR_W], sum[0], sh_q[MPLR_W-1:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= OP_MUL;
    end else begin
      done_q <= !cmd_i.start && busy_q && (cnt_q == '0);
      if (cmd_i.start) begin
        busy_q <= 1'b1;
        op_q   <= cmd_i.op;
        cnt_q  <= (cmd_i.op == OP_DIV) ? UNIT_CNT_BITS'(DIV_STEPS - 1)
                                       : UNIT_CNT_BITS'(MUL_STEPS - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      acc_q <= '0;
      if (cmd_i.op == OP_DIV) begin
        sh_q   <= cmd_i.a;
        opnd_q <= {{(MCAND_W-DIVR_W){1'b0}}, cmd_i.b[DIVR_W-1:0]};
      end else begin
        sh_q   <= {{(PROD_W-MPLR_W){1'b0}}, cmd_i.b};
        opnd_q <= cmd_i.a[MCAND_W-1:0];
      end
    end else if (busy_q) begin
      acc_q <= acc_d;
      sh_q  <= sh_d;
    end
  end

  assign sts_o.done = done_q;
  assign sts_o.res  = (op_q == OP_DIV) ? sh_q : {acc_q[MCAND_W-1:0], sh_q[MPLR_W-1:0]};

endmodule

// ----- hw/rtl/take_back_half_controller_unit.sv -----
// Top level of the take-back-half controller: sequencer and integral / drive datapath.
// Depends on tbc_pkg, tbc_if, tbc_cfg_regs and tbc_serial_unit.
//
//   channel   dir  handshake      payload
//   sample_i  in   valid / ready  measurement[15:0], now[31:0]
//   result_o  out  valid / ready  updated, drive[16:0]
//   cfg_i     in   valid / ready  index[2:0], data[31:0]
//
// An item that runs an update makes four serial unit passes, one bit per cycle (ki*|err|,
// times elapsed+interval, divide by interval, kp*|err|); an item that does not update
// goes from ST_PREP straight to ST_FINISH.
// sample_i.ready is high only while the sequencer is idle. The result register
// holds its transaction until taken; a finished item waits only if it is still full.
// Reset is asynchronous; the item payload and serial unit datapath registers are not reset.
module take_back_half_controller_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  tbc_sample_if.sink   sample_i,
  tbc_result_if.source result_o,
  tbc_cfg_if.sink      cfg_i
);
  import tbc_pkg::*;

  tbc_cfg_t   cfg;
  tbc_cmd_t   cmd;
  tbc_sts_t   sts;
  tbc_state_e state_q, state_d;

  tbc_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  tbc_serial_unit u_serial_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .sts_o  (sts)
  );

  // item payload
  logic [SAMPLE_BITS-1:0] meas_q, mag_q, mag_d;
  logic [TIME_BITS-1:0]   now_q;
  logic                   err_neg_q, err_neg_d;
  logic [MPLR_W-1:0]      span_q;
  logic                   upd_q;

  // controller state
  logic [TIME_BITS-1:0]   next_due_q;
  logic [FIX_BITS-1:0]    integral_q, cross_q;
  logic [SAMPLE_BITS-1:0] prev_q;
  logic                   have_prev_q, have_cross_q;
  logic [DRIVE_BITS-1:0]  last_drive_q;

  logic                   res_valid_q, res_updated_q;
  logic [DRIVE_BITS-1:0]  res_drive_q;

  logic                   accept, run, crossing, total_sat, sum_over;
  logic [TIME_BITS-1:0]   iv_eff;
  logic [TOTAL_W-1:0]     total;
  logic [INT_EXT_W-1:0]   integ_sum;
  logic [FIX_BITS-1:0]    integ_sat, avg, limited;
  logic [FIX_BITS:0]      pair, rounded;
  logic [SUM_W-1:0]       int_ext, prod_ext, drive_sum;
  logic [DRIVE_BITS-1:0]  drive_new;

  assign sample_i.ready  = (state_q == ST_IDLE);
  assign accept          = sample_i.valid && sample_i.ready;

  assign result_o.valid   = res_valid_q;
  assign result_o.updated = res_updated_q;
  assign result_o.drive   = res_drive_q;

  // error sign and magnitude, taken at acceptance
  assign err_neg_d = sample_i.measurement > cfg.set_point;
  assign mag_d     = err_neg_d ? sample_i.measurement - cfg.set_point
                               : cfg.set_point - sample_i.measurement;

  assign iv_eff = (cfg.update_interval == '0) ? TIME_BITS'(1) : cfg.update_interval;
  assign run    = cfg.enable && (now_q >= next_due_q);

  // integral step, capped at 2^33
  assign total_sat = (|sts.res[PROD_W-1:TOTAL_W])
                  || (sts.res[TOTAL_W-1] && (|sts.res[TOTAL_W-2:0]));
  assign total     = total_sat ? STEP_CAP : sts.res[TOTAL_W-1:0];
  assign integ_sum = err_neg_q
    ? {{(INT_EXT_W-FIX_BITS){integral_q[FIX_BITS-1]}}, integral_q} - {2'b00, total}
    : {{(INT_EXT_W-FIX_BITS){integral_q[FIX_BITS-1]}}, integral_q} + {2'b00, total};

  always_comb begin
    if (integ_sum[INT_EXT_W-1:FIX_BITS-1] == '0 || integ_sum[INT_EXT_W-1:FIX_BITS-1] == '1) begin
      integ_sat = integ_sum[FIX_BITS-1:0];
    end else if (integ_sum[INT_EXT_W-1]) begin
      integ_sat = {1'b1, {(FIX_BITS-1){1'b0}}};
    end else begin
      integ_sat = {1'b0, {(FIX_BITS-1){1'b1}}};
    end
  end

  // crossing detect and average, truncated toward zero
  assign crossing = have_prev_q &&
                    ((prev_q < cfg.set_point && meas_q >= cfg.set_point) ||
                     (prev_q > cfg.set_point && meas_q <= cfg.set_point));
  assign pair     = {integral_q[FIX_BITS-1], integral_q} + {cross_q[FIX_BITS-1], cross_q};
  assign rounded  = pair + {{FIX_BITS{1'b0}}, pair[FIX_BITS]};
  assign avg      = rounded[FIX_BITS:1];

  always_comb begin
    if ($signed(integral_q) < $signed(cfg.int_low)) begin
      limited = '0;
    end else if ($signed(integral_q) > $signed(cfg.int_high)) begin
      limited = ONE_Q24;
    end else begin
      limited = integral_q;
    end
  end

  // kp*err + integral, clamped to 0..1.0 and cut to Q1.16
  assign int_ext   = {{(SUM_W-FIX_BITS){integral_q[FIX_BITS-1]}}, integral_q};
  assign prod_ext  = {2'b00, sts.res[MCAND_W-1:0]};
  assign drive_sum = err_neg_q ? int_ext - prod_ext : int_ext + prod_ext;
  assign sum_over  = (|drive_sum[SUM_W-2:FRAC_BITS+1])
                  || (drive_sum[FRAC_BITS] && (|drive_sum[FRAC_BITS-1:0]));

  always_comb begin
    if (drive_sum[SUM_W-1]) begin
      drive_new = '0;
    end else if (sum_over) begin
      drive_new = DRIVE_FULL;
    end else begin
      drive_new = drive_sum[FRAC_BITS:FRAC_BITS-DRIVE_BITS+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cmd.start = 1'b0;
    cmd.op    = OP_MUL;
    cmd.a     = '0;
    cmd.b     = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_PREP;
      end
      ST_PREP: begin
        if (run) begin
          cmd.start = 1'b1;
          cmd.a     = {{(PROD_W-GAIN_BITS){1'b0}}, cfg.ki_gain};
          cmd.b     = {{(MPLR_W-SAMPLE_BITS){1'b0}}, mag_q};
          state_d   = ST_MUL_STEP;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_MUL_STEP: begin
        if (sts.done) begin
          cmd.start = 1'b1;
          cmd.a     = {{MPLR_W{1'b0}}, sts.res[MCAND_W-1:0]};
          cmd.b     = span_q;
          state_d   = ST_MUL_SPAN;
        end
      end
      ST_MUL_SPAN: begin
        if (sts.done) begin
          cmd.start = 1'b1;
          cmd.op    = OP_DIV;
          cmd.a     = sts.res;
          cmd.b     = {1'b0, iv_eff};
          state_d   = ST_DIV_SPAN;
        end
      end
      ST_DIV_SPAN: begin
        if (sts.done) state_d = ST_INTEG;
      end
      ST_INTEG: state_d = ST_CROSS;
      ST_CROSS: state_d = ST_LIMIT;
      ST_LIMIT: begin
        cmd.start = 1'b1;
        cmd.a     = {{(PROD_W-GAIN_BITS){1'b0}}, cfg.kp_gain};
        cmd.b     = {{(MPLR_W-SAMPLE_BITS){1'b0}}, mag_q};
        state_d   = ST_MUL_KP;
      end
      ST_MUL_KP: begin
        if (sts.done) state_d = ST_DRIVE;
      end
      ST_DRIVE: state_d = ST_FINISH;
      ST_FINISH: begin
        if (!res_valid_q || result_o.ready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_due_q    <= '0;
      integral_q    <= '0;
      cross_q       <= '0;
      prev_q        <= '0;
      have_prev_q   <= 1'b0;
      have_cross_q  <= 1'b0;
      last_drive_q  <= '0;
      upd_q         <= 1'b0;
      res_valid_q   <= 1'b0;
      res_updated_q <= 1'b0;
      res_drive_q   <= '0;
    end else begin
      if (res_valid_q && result_o.ready && state_q != ST_FINISH) res_valid_q <= 1'b0;
      unique case (state_q)
        ST_PREP: begin
          upd_q <= run;
          if (run) next_due_q <= now_q + iv_eff;
        end
        ST_INTEG: integral_q <= integ_sat;
        ST_CROSS: begin
          // first crossing only saves the integral
          if (crossing) begin
            if (have_cross_q) begin
              integral_q <= avg;
              cross_q    <= avg;
            end else begin
              cross_q    <= integral_q;
            end
            have_cross_q <= 1'b1;
          end
          prev_q      <= meas_q;
          have_prev_q <= 1'b1;
        end
        ST_LIMIT: integral_q   <= limited;
        ST_DRIVE: last_drive_q <= drive_new;
        ST_FINISH: begin
          if (!res_valid_q || result_o.ready) begin
            res_valid_q   <= 1'b1;
            res_updated_q <= upd_q;
            res_drive_q   <= last_drive_q;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      meas_q    <= sample_i.measurement;
      now_q     <= sample_i.now;
      err_neg_q <= err_neg_d;
      mag_q     <= mag_d;
    end
    if (state_q == ST_PREP) begin
      // elapsed since due plus one interval
      span_q <= {1'b0, now_q - next_due_q} + {1'b0, iv_eff};
    end
  end

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for take_back_half_controller_unit: directed and random samples,
// register writes between phases, scoreboard class with a bit-exact drive predictor.
// Depends on tbc_pkg, tbc_if and the controller RTL.
module testbench;
  import tbc_pkg::*;

  localparam int          CYCLE_LIMIT   = 2_500_000;
  localparam int          ITEM_TARGET   = 1900;
  localparam int          MAX_GAP       = 18;
  localparam longint      FULL_SCALE    = 64'sd16777216;
  localparam longint      SAT_HI        = 64'sd2147483647;
  localparam longint      SAT_LO        = -64'sd2147483648;
  localparam logic [127:0] INTEG_STEP_CAP = 128'd1 << 33;

  typedef struct packed {
    logic                  updated;
    logic [DRIVE_BITS-1:0] drive;
  } drive_result_t;

  class drive_scoreboard;
    logic [SAMPLE_BITS-1:0] set_point;
    logic [GAIN_BITS-1:0]   kp_gain;
    logic [GAIN_BITS-1:0]   ki_gain;
    logic [TIME_BITS-1:0]   interval;
    logic                   enabled;
    longint                 int_low;
    longint                 int_high;
    logic [TIME_BITS-1:0]   next_due;
    longint                 integral;
    longint                 cross_integral;
    logic [SAMPLE_BITS-1:0] prev_meas;
    bit                     have_prev;
    bit                     have_cross;
    logic [DRIVE_BITS-1:0]  last_drive;
    drive_result_t          pending_q[$];
    int                     samples_noted;
    int                     results_seen;
    int                     mismatch_count;

    function new();
      set_point = '0;
      kp_gain = '0;
      ki_gain = '0;
      interval = IV_RESET;
      enabled = 1'b0;
      int_low = 0;
      int_high = FULL_SCALE;
      next_due = '0;
      integral = 0;
      cross_integral = 0;
      prev_meas = '0;
      have_prev = 1'b0;
      have_cross = 1'b0;
      last_drive = '0;
      samples_noted = 0;
      results_seen = 0;
      mismatch_count = 0;
    endfunction

    function void apply_reg(tbc_reg_e idx, logic [CFG_DATA_BITS-1:0] value);
      case (idx)
        REG_SET_POINT: set_point = value[SAMPLE_BITS-1:0];
        REG_KP_GAIN:   kp_gain = value[GAIN_BITS-1:0];
        REG_KI_GAIN:   ki_gain = value[GAIN_BITS-1:0];
        REG_INTERVAL:  interval = value[TIME_BITS-1:0];
        REG_ENABLE:    enabled = value[0];
        REG_INT_LOW:   int_low = longint'($signed(value));
        REG_INT_HIGH:  int_high = longint'($signed(value));
        default: ;
      endcase
    endfunction

    // Work out the result of one accepted sample and queue it.
    function void note_sample(logic [SAMPLE_BITS-1:0] meas, logic [TIME_BITS-1:0] t);
      logic [TIME_BITS-1:0] iv;
      logic [TIME_BITS-1:0] elapsed;
      logic [127:0]         step;
      logic [127:0]         whole;
      logic [127:0]         rem;
      logic [127:0]         mult;
      logic [127:0]         total;
      longint               err;
      longint               mag;
      longint               acc;
      longint               sum;
      samples_noted++;
      if (!enabled || t < next_due) begin
        pending_q.push_back({1'b0, last_drive});
        return;
      end
      iv = (interval == '0) ? TIME_BITS'(1) : interval;
      err = longint'(set_point) - longint'(meas);
      mag = (err < 0) ? -err : err;
      step = 128'(ki_gain) * 128'(mag);
      elapsed = t - next_due;
      whole = 128'(elapsed / iv);
      rem = 128'(elapsed % iv);
      if (step == 0) begin
        total = '0;
      end else begin
        mult = ((whole > INTEG_STEP_CAP) ? INTEG_STEP_CAP : whole) + 128'd1;
        if (step > INTEG_STEP_CAP / mult) begin
          total = INTEG_STEP_CAP;
        end else begin
          // fractional interval counts as step * rem / iv, truncated
          total = step * mult + (step * rem) / 128'(iv);
          if (total > INTEG_STEP_CAP) total = INTEG_STEP_CAP;
        end
      end
      next_due = t + iv;
      acc = (err < 0) ? integral - longint'(total[33:0]) : integral + longint'(total[33:0]);
      if (acc > SAT_HI) acc = SAT_HI;
      else if (acc < SAT_LO) acc = SAT_LO;
      integral = acc;
      if (have_prev && ((prev_meas < set_point && meas >= set_point) ||
                        (prev_meas > set_point && meas <= set_point))) begin
        // first crossing only records the integral
        if (have_cross) integral = (integral + cross_integral) / 2;
        else have_cross = 1'b1;
        cross_integral = integral;
      end
      prev_meas = meas;
      have_prev = 1'b1;
      if (integral < int_low) integral = 0;
      else if (integral > int_high) integral = FULL_SCALE;
      sum = longint'(kp_gain) * err + integral;
      if (sum < 0) sum = 0;
      else if (sum > FULL_SCALE) sum = FULL_SCALE;
      last_drive = DRIVE_BITS'(sum >>> 8);
      pending_q.push_back({1'b1, last_drive});
    endfunction

    task report_mismatch(string msg);
      mismatch_count++;
      $display("MISMATCH: %s", msg);
    endtask

    task check_result(logic updated, logic [DRIVE_BITS-1:0] drive);
      drive_result_t want;
      results_seen++;
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing pending", results_seen));
        return;
      end
      want = pending_q.pop_front();
      if (updated !== want.updated)
        report_mismatch($sformatf("result %0d updated %b, predicted %b",
                                  results_seen, updated, want.updated));
      if (drive !== want.drive)
        report_mismatch($sformatf("result %0d drive %h, predicted %h",
                                  results_seen, drive, want.drive));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  bit   gaps_on;
  logic [TIME_BITS-1:0] stamp;
  int unsigned cycle_count = 0;
  drive_scoreboard sb;

  tbc_sample_if sample_bus ();
  tbc_result_if result_bus ();
  tbc_cfg_if    cfg_bus ();

  take_back_half_controller_unit dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_bus),
    .result_o (result_bus),
    .cfg_i    (cfg_bus)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance with valid held.
  task automatic send_sample(input logic [SAMPLE_BITS-1:0] meas,
                             input logic [TIME_BITS-1:0] t);
    int gap;
    gap = gaps_on ? $urandom_range(MAX_GAP, 0) : 0;
    if (gap > 0) begin
      sample_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    sample_bus.valid       <= 1'b1;
    sample_bus.measurement <= meas;
    sample_bus.now         <= t;
    do @(posedge clk_i); while (!sample_bus.ready);
    sb.note_sample(meas, t);
    @(negedge clk_i);
  endtask

  // Drop valid and hold until every predicted result has come back.
  task automatic wait_for_drain();
    sample_bus.valid <= 1'b0;
    do @(negedge clk_i); while (sb.pending_q.size() != 0);
  endtask

  task automatic write_reg(input tbc_reg_e idx, input logic [CFG_DATA_BITS-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk_i); while (!cfg_bus.ready);
    sb.apply_reg(idx, value);
    @(negedge clk_i);
  endtask

  task automatic program_all(input logic [CFG_DATA_BITS-1:0] sp, kp, ki, iv, en, lo, hi);
    wait_for_drain();
    repeat (4) @(negedge clk_i);
    write_reg(REG_SET_POINT, sp);
    write_reg(REG_KP_GAIN, kp);
    write_reg(REG_KI_GAIN, ki);
    write_reg(REG_INTERVAL, iv);
    write_reg(REG_ENABLE, en);
    write_reg(REG_INT_LOW, lo);
    write_reg(REG_INT_HIGH, hi);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic run_random_phase();
    logic [SAMPLE_BITS-1:0] sp;
    logic [SAMPLE_BITS-1:0] meas;
    logic [GAIN_BITS-1:0]   kp;
    logic [GAIN_BITS-1:0]   ki;
    logic [TIME_BITS-1:0]   iv;
    logic [TIME_BITS-1:0]   lo;
    logic [TIME_BITS-1:0]   hi;
    logic [TIME_BITS-1:0]   t;
    logic                   en;
    bit                     rising;
    bit                     noisy;
    int                     n;
    int                     amp_max;
    int                     level;
    int                     pick;
    longint unsigned        adv;
    longint unsigned        iv_eff;
    pick = $urandom_range(9, 0);
    sp = (pick == 0) ? '0 : (pick == 1) ? '1 : SAMPLE_BITS'($urandom());
    kp = (pick == 2) ? '1 : GAIN_BITS'($urandom()) >> $urandom_range(GAIN_BITS, 0);
    ki = (pick == 3) ? '1 : GAIN_BITS'($urandom()) >> $urandom_range(GAIN_BITS, 0);
    pick = $urandom_range(15, 0);
    if (pick == 0) iv = '1;
    else if (pick == 1) iv = '0;
    else if (pick < 6) iv = $urandom_range(20, 1);
    else if (pick < 12) iv = $urandom_range(3000, 21);
    else iv = $urandom_range(200000, 3001);
    en = ($urandom_range(7, 0) != 0);
    pick = $urandom_range(7, 0);
    lo = (pick == 0) ? 32'h8000_0000 : (pick == 1) ? 32'h7FFF_FFFF :
         32'(-$urandom_range(32'h0200_0000, 0));
    pick = $urandom_range(7, 0);
    hi = (pick == 0) ? 32'h7FFF_FFFF : (pick == 1) ? 32'h8000_0000 :
         32'h0100_0000 + $urandom_range(32'h0040_0000, 0) - 32'h0020_0000;
    // junk above each register width must be ignored
    program_all({16'($urandom()), sp}, {8'($urandom()), kp}, {8'($urandom()), ki}, iv,
                {31'($urandom()), en}, lo, hi);
    stamp = sb.next_due;
    gaps_on = ($urandom_range(3, 0) != 0);
    n = $urandom_range(120, 40);
    case ($urandom_range(4, 0))
      0: amp_max = 0;
      1: amp_max = 3;
      2: amp_max = 300;
      3: amp_max = 6000;
      default: amp_max = 65535;
    endcase
    iv_eff = (iv == '0) ? 64'd1 : 64'(iv);
    rising = 1'($urandom_range(1, 0));
    repeat (n) begin
      if ($urandom_range(63, 0) == 0) wait_for_drain();
      noisy = ($urandom_range(15, 0) == 0);
      if (noisy) begin
        meas = SAMPLE_BITS'($urandom());
        t = $urandom();
      end else begin
        // swing around the set point so crossings come often
        if ($urandom_range(3, 0) == 0) rising = !rising;
        level = rising ? int'(sp) + $urandom_range(amp_max, 0)
                       : int'(sp) - $urandom_range(amp_max, 0);
        meas = (level > 65535) ? '1 : (level < 0) ? '0 : SAMPLE_BITS'(level);
        pick = $urandom_range(15, 0);
        if (pick < 2) adv = 64'($urandom_range(32'(iv_eff - 1), 0));
        else if (pick < 12) adv = iv_eff + 64'($urandom_range(32'(iv_eff / 4), 0));
        else if (pick < 14) adv = iv_eff * 64'($urandom_range(6, 2));
        else if (pick == 14) adv = 0;
        else adv = 64'($urandom_range(32'h0010_0000, 0));
        stamp = stamp + TIME_BITS'(adv);
        t = stamp;
      end
      send_sample(meas, t);
      // resync to the time of the last update
      if (noisy) stamp = sb.next_due - TIME_BITS'(iv_eff);
    end
  endtask

  initial begin : result_sink
    int gap;
    result_bus.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      gap = gaps_on ? $urandom_range(MAX_GAP, 0) : 0;
      if (gap > 0) begin
        result_bus.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      result_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!result_bus.valid);
      sb.check_result(result_bus.updated, result_bus.drive);
      @(negedge clk_i);
    end
  end

  initial begin : stimulus
    int phase_count;
    sb = new();
    gaps_on = 1'b1;
    rst_ni <= 1'b0;
    sample_bus.valid       <= 1'b0;
    sample_bus.measurement <= '0;
    sample_bus.now         <= '0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= REG_SET_POINT;
    cfg_bus.data  <= '0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // disabled after reset: drive held at zero
    send_sample(16'h0000, 32'h0000_0000);
    send_sample(16'hFFFF, 32'hFFFF_FFFF);

    // zero interval acts as one; crossings, not-yet-due, huge elapsed time
    program_all(32'h0000_8000, 32'h0000_0100, 32'h0000_1000, 32'h0000_0000,
                32'h0000_0001, 32'hFF00_0000, 32'h0200_0000);
    send_sample(16'h0000, 32'd10);
    send_sample(16'h0000, 32'd10);
    send_sample(16'hFFFF, 32'd11);
    send_sample(16'h8000, 32'd13);
    send_sample(16'h7000, 32'd20);
    send_sample(16'h9000, 32'hFFFF_FFF0);

    // full-scale gains and thresholds, interval wrapping the due time
    program_all(32'h0000_FFFF, 32'h00FF_FFFF, 32'h00FF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_sample(16'h0000, 32'hFFFF_FFFF);
    send_sample(16'hFFFF, 32'hFFFF_FFFE);
    send_sample(16'hFFFF, 32'h0000_0000);
    send_sample(16'h1234, 32'hFFFF_FFFD);

    // zero gains, low threshold above high threshold
    program_all(32'hFFFF_0000, 32'hFF00_0000, 32'hFF00_0000, 32'h0000_0001,
                32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000);
    send_sample(16'hFFFF, 32'hFFFF_FFFC);
    send_sample(16'h0000, 32'hFFFF_FFFE);

    // enable bit clear with upper bits set
    program_all(32'hFFFF_0000, 32'hFF00_0000, 32'hFF00_0000, 32'h0000_0001,
                32'hFFFF_FFFE, 32'h7FFF_FFFF, 32'h8000_0000);
    send_sample(16'h4321, 32'hFFFF_FFFF);

    phase_count = 0;
    while (sb.samples_noted < ITEM_TARGET && phase_count < 50) begin
      run_random_phase();
      phase_count++;
    end

    wait_for_drain();
    repeat (200) @(negedge clk_i);
    if (sb.mismatch_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
